FILE: hdl/suse_pkg.sv
// Shared types and codes for the sorted unique set engine.
package suse_pkg;

  localparam int SUSE_CAPACITY = 32;
  localparam int VALUE_W       = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST_ASC  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_DESC = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY_DEL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd6;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROT_LEFT,
    OP_ROT_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  key;
  } cell_ctl_t;

endpackage

FILE: hdl/suse_if.sv
// Valid/ready channel interfaces for commands and results.
interface suse_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [suse_pkg::CMD_W-1:0]             cmd;
  logic signed [suse_pkg::VALUE_W-1:0]    key_value;

  modport source (output valid, output cmd, output key_value, input ready);
  modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

interface suse_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [suse_pkg::VALUE_W-1:0]    out_value;
  logic [suse_pkg::STATUS_W-1:0]          status;
  logic                                   empty_listing;
  logic                                   last_result;

  modport source (output valid, output out_value, output status,
                  output empty_listing, output last_result, input ready);
  modport sink   (input valid, input out_value, input status,
                  input empty_listing, input last_result, output ready);
endinterface

FILE: hdl/sorted_unique_set_engine_core.sv
// Top level of the sorted unique set engine: a chain of compare-and-shift cells.
//
// Commands arrive on in_ch (cmd, key_value) and results leave on out_ch, both
// valid/ready channels; an item moves when valid and ready are high together.
// The set lives in a row of CAPACITY cells, held in ascending order in cells
// 0 .. count-1. Every cell compares its element with the key in parallel, so
// an insert or delete is applied in the cycle the item is accepted, and its
// single result sits in the output register on the next cycle. Updates and
// empty listings therefore run at one item per cycle while out_ch keeps up.
// A listing of n elements occupies the chain while the ring of cells
// is rotated left n times and then right n times, which brings every element
// back to its place. An ascending listing emits cell 0 during the left
// rotation, a descending listing emits the top cell during the right one,
// one element per cycle with last_result on the final one. While a listing
// runs no new item is accepted. When out_ch stalls, the output register holds
// its result and the chain waits before each emitting step. A synchronous
// reset empties the set and the output register; cell contents are
// not cleared, since only occupied cells are ever read.
module sorted_unique_set_engine_core #(
  parameter int CAPACITY = suse_pkg::SUSE_CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  suse_in_if.sink         in_ch,
  suse_out_if.source      out_ch
);
  import suse_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FWD  = 3'b010,
    S_BACK = 3'b100
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] step, step_next;
  logic          desc, desc_next;

  logic                      ov;
  logic signed [VALUE_W-1:0] ov_value;
  logic [STATUS_W-1:0]       ov_status;
  logic                      ov_empty;
  logic                      ov_last;

  logic                      emit;
  logic signed [VALUE_W-1:0] emit_value;
  logic [STATUS_W-1:0]       emit_status;
  logic                      emit_empty;
  logic                      emit_last;

  cell_ctl_t ctl;
  logic signed [VALUE_W-1:0] val [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] occ_v;

  logic slot_free;
  logic in_fire;
  logic any_eq;
  logic full;
  logic final_step;

  // ---------------------------------------------------------------------
  // Cell chain. Rotation closes the row into a ring; an insert treats the
  // space left of cell 0 as "below the key".
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_lt;
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    assign occ_v[i] = CW'(i) < count;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = val[CAPACITY-1];
    end else begin : g_mid
      assign left_lt  = lt_v[i-1];
      assign left_val = val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = val[0];
    end else begin : g_inner
      assign right_val = val[i+1];
    end

    suse_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_v[i]),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .value     (val[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i])
    );
  end

  assign any_eq     = |eq_v;
  assign full       = (count == CW'(CAPACITY));
  assign final_step = (step == count - CW'(1));

  // The output register can take a new result when empty or being drained.
  assign slot_free    = !ov || out_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) && slot_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------
  // Control: decides what the chain does and which result is produced.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next  = state;
    count_next  = count;
    step_next   = step;
    desc_next   = desc;
    ctl.op      = OP_HOLD;
    ctl.key     = in_ch.key_value;
    emit        = 1'b0;
    emit_value  = in_ch.key_value;
    emit_status = ST_ELEMENT;
    emit_empty  = 1'b0;
    emit_last   = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          emit = 1'b1;
          if (in_ch.cmd == CMD_INSERT) begin
            if (any_eq) begin
              emit_status = ST_DUPLICATE;
            end else if (full) begin
              emit_status = ST_FULL;
            end else begin
              emit_status = ST_INSERTED;
              ctl.op      = OP_INSERT;
              count_next  = count + CW'(1);
            end
          end else if (in_ch.cmd == CMD_DELETE) begin
            if (count == '0) begin
              emit_status = ST_EMPTY_DEL;
            end else if (any_eq) begin
              emit_status = ST_DELETED;
              ctl.op      = OP_DELETE;
              count_next  = count - CW'(1);
            end else begin
              emit_status = ST_NOT_FOUND;
            end
          end else if (count == '0) begin
            // A listing of an empty set gives one marked result.
            emit_value = '0;
            emit_empty = 1'b1;
          end else begin
            emit       = 1'b0;
            desc_next  = (in_ch.cmd == CMD_LIST_DESC);
            step_next  = '0;
            state_next = S_FWD;
          end
        end
      end

      S_FWD: begin
        emit_value = val[0];
        emit_last  = final_step;
        if (desc || slot_free) begin
          emit   = !desc;
          ctl.op = OP_ROT_LEFT;
          if (final_step) begin
            step_next  = '0;
            state_next = S_BACK;
          end else begin
            step_next = step + CW'(1);
          end
        end
      end

      S_BACK: begin
        emit_value = val[CAPACITY-1];
        emit_last  = final_step;
        if (!desc || slot_free) begin
          emit   = desc;
          ctl.op = OP_ROT_RIGHT;
          if (final_step) begin
            step_next  = '0;
            state_next = S_IDLE;
          end else begin
            step_next = step + CW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
      desc  <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      desc  <= desc_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ov_value  <= emit_value;
      ov_status <= emit_status;
      ov_empty  <= emit_empty;
      ov_last   <= emit_last;
    end
  end

  assign out_ch.valid         = ov;
  assign out_ch.out_value     = ov_value;
  assign out_ch.status        = ov_status;
  assign out_ch.empty_listing = ov_empty;
  assign out_ch.last_result   = ov_last;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.cmd == CMD_INSERT) |=>
      ((count == $past(count) + CW'(1)) == (out_ch.status == ST_INSERTED)))
    else $error("insert status disagrees with count change");

  a_listing_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count != '0))
    else $error("listing running on an empty set");

  a_listing_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count)))
    else $error("element count changed during a listing");
`endif

endmodule

FILE: hdl/suse_cell.sv
// One storage cell of the sorted chain: compares against the key and shifts.
module suse_cell (
  input  logic                                clk,
  input  suse_pkg::cell_ctl_t                 ctl,
  input  logic                                occ,
  input  logic                                left_lt,
  input  logic signed [suse_pkg::VALUE_W-1:0] left_val,
  input  logic signed [suse_pkg::VALUE_W-1:0] right_val,
  output logic signed [suse_pkg::VALUE_W-1:0] value,
  output logic                                lt,
  output logic                                eq
);
  import suse_pkg::*;

  logic signed [VALUE_W-1:0] value_next;

  assign lt = occ && ($signed(value) < $signed(ctl.key));
  assign eq = occ && (value == ctl.key);

  always_comb begin
    value_next = value;
    case (ctl.op)
      OP_HOLD:      value_next = value;
      // Cells below the insertion point keep their element; the first cell
      // at or above it takes the key and the rest move up by one.
      OP_INSERT:    value_next = lt ? value : (left_lt ? ctl.key : left_val);
      // Cells at or above the deleted element move down by one.
      OP_DELETE:    value_next = lt ? value : right_val;
      OP_ROT_LEFT:  value_next = right_val;
      OP_ROT_RIGHT: value_next = left_val;
      default:      value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the sorted unique set engine core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import suse_pkg::*;

  localparam int CAP            = SUSE_CAPACITY;
  localparam int RESET_CYCLES   = 9;
  localparam int TOTAL_ITEMS    = 230;
  localparam int HOLD_CYCLES    = 150;
  // A full listing keeps the chain busy for two passes over the set.
  localparam int SETTLE_CYCLES  = 2 * CAP + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 40;
  localparam int MAX_REPORTS    = 40;

  // One result item as it leaves the block.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic                      empty;
    logic                      last;
  } set_result_t;

  // Tracks the contents of the set, predicts the result items of every
  // accepted command and checks the result items against them in order.
  class sorted_set_tracker;
    logic signed [VALUE_W-1:0] members[$];
    set_result_t               pending_results[$];
    int unsigned               mismatches;

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] key);
      int          pos;
      int          n;
      bit          hit;
      set_result_t r;
      r.value  = key;
      r.status = ST_ELEMENT;
      r.empty  = 1'b0;
      r.last   = 1'b1;
      n        = members.size();
      pos      = 0;
      while (pos < n && members[pos] < key) pos++;
      hit = (pos < n) && (members[pos] == key);
      case (cmd)
        CMD_INSERT: begin
          if (hit) begin
            r.status = ST_DUPLICATE;
          end else if (n >= CAP) begin
            r.status = ST_FULL;
          end else begin
            members.insert(pos, key);
            r.status = ST_INSERTED;
          end
          pending_results.push_back(r);
        end
        CMD_DELETE: begin
          if (n == 0) begin
            r.status = ST_EMPTY_DEL;
          end else if (hit) begin
            members.delete(pos);
            r.status = ST_DELETED;
          end else begin
            r.status = ST_NOT_FOUND;
          end
          pending_results.push_back(r);
        end
        default: begin
          if (n == 0) begin
            r.value = '0;
            r.empty = 1'b1;
            pending_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.value = (cmd == CMD_LIST_ASC) ? members[i] : members[n-1-i];
              r.last  = (i == n - 1);
              pending_results.push_back(r);
            end
          end
        end
      endcase
    endfunction

    function void flag_mismatch(string field, logic signed [VALUE_W-1:0] want,
                                logic signed [VALUE_W-1:0] got);
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(set_result_t got);
      set_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                   $time, got.value, got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value)   flag_mismatch("out_value", want.value, got.value);
      if (got.status !== want.status)
        flag_mismatch("status", VALUE_W'(want.status), VALUE_W'(got.status));
      if (got.empty !== want.empty)
        flag_mismatch("empty_listing", VALUE_W'(want.empty), VALUE_W'(got.empty));
      if (got.last !== want.last)
        flag_mismatch("last_result", VALUE_W'(want.last), VALUE_W'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  suse_in_if  in_ch();
  suse_out_if out_ch();

  sorted_unique_set_engine_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_set_tracker tracker = new();

  logic signed [VALUE_W-1:0] key_pool[POOL_SIZE];
  int unsigned items_sent;
  bit          sender_steady;
  bit          hold_request;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Picks the length of an idle stretch from three bands, the shortest most often and the longest seldom.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly keys from a small pool so that duplicates and hits are common,
  // the rest from the whole 32-bit range.
  function automatic logic signed [VALUE_W-1:0] random_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Offers one item, returns at the edge where it was accepted, or after
  // the idle gap that follows it.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [VALUE_W-1:0] key);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.key_value <= key;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_command(cmd, key);
    items_sent++;
    gap = 0;
    if (!sender_steady && $urandom_range(0, 99) < 35) gap = idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_command(CMD_LIST_ASC, 32'sd0);             // listing of an empty set
    send_command(CMD_LIST_DESC, -32'sd1);
    send_command(CMD_DELETE, 32'sd5);               // delete from an empty set
    send_command(CMD_INSERT, 32'sh8000_0000);       // most negative value
    send_command(CMD_INSERT, 32'sh7fff_ffff);       // most positive value
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, -32'sd1);
    send_command(CMD_INSERT, 32'sd1);
    send_command(CMD_INSERT, 32'sd0);               // duplicate
    send_command(CMD_LIST_ASC, 32'sh5a5a_5a5a);
    send_command(CMD_LIST_DESC, 32'sh8000_0000);
    send_command(CMD_DELETE, 32'sd12345);           // absent from a non-empty set
    send_command(CMD_DELETE, 32'sh8000_0000);
    send_command(CMD_DELETE, 32'sh7fff_ffff);
    send_command(CMD_DELETE, 32'sd0);
    send_command(CMD_LIST_ASC, 32'sd0);
    send_command(CMD_DELETE, -32'sd1);
    send_command(CMD_DELETE, 32'sd1);               // set is empty again
    send_command(CMD_LIST_DESC, 32'sd0);
    send_command(CMD_INSERT, 32'sh5555_5555);
    send_command(CMD_INSERT, 32'shaaaa_aaaa);
    send_command(CMD_LIST_ASC, 32'shffff_ffff);
  endtask

  // Fills the set, then tries a new value and an existing one while it is
  // full, and lists it both ways.
  task automatic fill_to_capacity();
    while (tracker.members.size() < CAP) send_command(CMD_INSERT, random_key());
    send_command(CMD_INSERT, $urandom);
    send_command(CMD_INSERT, tracker.members[$urandom_range(0, CAP - 1)]);
    send_command(CMD_LIST_ASC, $urandom);
    send_command(CMD_LIST_DESC, $urandom);
  endtask

  task automatic send_random_item();
    int unsigned               r;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] key;
    r   = $urandom_range(0, 99);
    key = random_key();
    if (r < 45) begin
      cmd = CMD_INSERT;
    end else if (r < 80) begin
      cmd = CMD_DELETE;
      if (tracker.members.size() > 0 && $urandom_range(0, 99) < 60)
        key = tracker.members[$urandom_range(0, tracker.members.size() - 1)];
    end else if (r < 90) begin
      cmd = CMD_LIST_ASC;
      key = $urandom;
    end else begin
      cmd = CMD_LIST_DESC;
      key = $urandom;
    end
    send_command(cmd, key);
  endtask

  // Stimulus: reset, the directed items, then random items with a fill to
  // capacity twice, one long output hold-off and one pause for the drain.
  initial begin
    int unsigned fills;
    bit          held;
    bit          paused;
    int unsigned last_mode_change;
    fills            = 0;
    held             = 1'b0;
    paused           = 1'b0;
    last_mode_change = 0;
    items_sent       = 0;
    sender_steady    = 1'b0;
    hold_request     = 1'b0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_INSERT;
    in_ch.key_value <= '0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    for (int i = 2; i < POOL_SIZE; i++) begin
      if (i < 10) key_pool[i] = $signed($urandom_range(0, 15)) - 8;
      else key_pool[i] = $urandom;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    while (items_sent < TOTAL_ITEMS) begin
      // Switch between bursts with no gaps and gappy stretches now and then.
      if (items_sent >= last_mode_change + 25) begin
        last_mode_change = items_sent;
        sender_steady    = ($urandom_range(0, 3) == 0);
      end
      if ((fills == 0 && items_sent >= 70) || (fills == 1 && items_sent >= 190)) begin
        fill_to_capacity();
        fills++;
      end else if (!held && items_sent >= 130) begin
        // The receiver stops taking results for a long stretch; the items
        // offered meanwhile back up until the input is stalled.
        hold_request = 1'b1;
        held         = 1'b1;
      end else if (!paused && items_sent >= 165) begin
        wait_for_results();
        paused = 1'b1;
      end else begin
        send_random_item();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, stretches of steady acceptance, and the
  // one long hold-off that the stimulus asks for.
  initial begin
    int unsigned stall_left;
    bit          steady;
    bit          hold_done;
    stall_left    = 0;
    steady        = 1'b0;
    hold_done     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = idle_length();
        if ($urandom_range(0, 149) == 0) steady = !steady;
      end
    end
  end

  // Every accepted result item goes to the tracker.
  always @(posedge clk) begin
    set_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.value  = out_ch.out_value;
      got.status = out_ch.status;
      got.empty  = out_ch.empty_listing;
      got.last   = out_ch.last_result;
      tracker.check_result(got);
    end
  end

  // Ends a run that has stopped moving items on either channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
